### rtl/core/orm_pkg.sv
// ----------------------------------------------------------------------------
// orm_pkg: shared types and constants of the rule match and rewrite unit
// Header, rule and pipeline payload layouts plus register and code names.
// ----------------------------------------------------------------------------
package orm_pkg;

	localparam int MAX_RULES = 6;
	localparam int ID_W      = 24;
	localparam int PROTO_W   = 3;
	localparam int CT_W      = 2;
	localparam int RULE_W    = 62;
	localparam int COUNT_W   = 3;
	localparam int IDX_W     = $clog2(MAX_RULES + 1);

	// Register indexes
	localparam logic [IDX_W-1:0] REG_RULE_COUNT = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_RULE_BASE  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_RULE_LAST  = IDX_W'(MAX_RULES);

	// Rewrite codes for timeslot and call type
	localparam logic [1:0] TS_SLOT_ONE = 2'd1;
	localparam logic [1:0] TS_SLOT_TWO = 2'd2;
	localparam logic [1:0] CT_GROUP    = 2'd1;
	localparam logic [1:0] CT_PRIVATE  = 2'd2;

	localparam logic [CT_W-1:0] CALL_GROUP   = CT_W'(0);
	localparam logic [CT_W-1:0] CALL_PRIVATE = CT_W'(1);

	typedef struct packed {
		logic               reject;
		logic               src_wild;
		logic [PROTO_W-1:0] orig_proto;
		logic               dst_wild;
		logic [PROTO_W-1:0] dest_proto;
		logic               modify;
		logic [1:0]         ct_code;
		logic [1:0]         ts_code;
		logic [ID_W-1:0]    rw_target_id;
		logic [ID_W-1:0]    rw_source_id;
	} rule_t;

	typedef struct packed {
		logic [PROTO_W-1:0] orig_proto;
		logic [PROTO_W-1:0] dest_proto;
		logic               timeslot;
		logic [CT_W-1:0]    call_type;
		logic [ID_W-1:0]    source_id;
		logic [ID_W-1:0]    target_id;
	} hdr_t;

	// Header as it moves down the cell chain
	typedef struct packed {
		hdr_t hdr;
		logic permit;
		logic done;
	} pay_t;

	// Rule set as seen by the cell chain
	typedef struct packed {
		rule_t [MAX_RULES-1:0] rules;
		logic  [MAX_RULES-1:0] active;
	} ruleset_t;

endpackage

### rtl/core/orm_hdr_if.sv
// ----------------------------------------------------------------------------
// orm_hdr_if: header input channel
// Valid/ready channel carrying one packet header per beat.
// ----------------------------------------------------------------------------
interface orm_hdr_if;
	logic                        valid;
	logic                        ready;
	logic [orm_pkg::PROTO_W-1:0] orig_proto;
	logic [orm_pkg::PROTO_W-1:0] dest_proto;
	logic                        timeslot;
	logic [orm_pkg::CT_W-1:0]    call_type;
	logic [orm_pkg::ID_W-1:0]    source_id;
	logic [orm_pkg::ID_W-1:0]    target_id;

	modport source (output valid, orig_proto, dest_proto, timeslot, call_type, source_id,
		target_id, input ready);
	modport sink (input valid, orig_proto, dest_proto, timeslot, call_type, source_id,
		target_id, output ready);
endinterface

### rtl/core/orm_res_if.sv
// ----------------------------------------------------------------------------
// orm_res_if: result output channel
// Valid/ready channel carrying one rewritten header and permit bit per beat.
// ----------------------------------------------------------------------------
interface orm_res_if;
	logic                     valid;
	logic                     ready;
	logic                     permit;
	logic                     new_timeslot;
	logic [orm_pkg::CT_W-1:0] new_call_type;
	logic [orm_pkg::ID_W-1:0] new_source_id;
	logic [orm_pkg::ID_W-1:0] new_target_id;

	modport source (output valid, permit, new_timeslot, new_call_type, new_source_id,
		new_target_id, input ready);
	modport sink (input valid, permit, new_timeslot, new_call_type, new_source_id,
		new_target_id, output ready);
endinterface

### rtl/core/orm_cfg_if.sv
// ----------------------------------------------------------------------------
// orm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface orm_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [orm_pkg::IDX_W-1:0]  index;
	logic [orm_pkg::RULE_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/orm_cfg.sv
// ----------------------------------------------------------------------------
// orm_cfg: configuration register file
// Holds the rule count and rule words; derives the per-rule active mask.
// ----------------------------------------------------------------------------
module orm_cfg (
	input  logic              clk,
	input  logic              arst_n,
	orm_cfg_if.sink           cfg,
	output orm_pkg::ruleset_t ruleset
);

	logic [orm_pkg::COUNT_W-1:0]        count_q;
	orm_pkg::rule_t [orm_pkg::MAX_RULES-1:0] rules_q;
	logic [orm_pkg::COUNT_W-1:0]        limit;
	logic                               wr;
	logic [orm_pkg::IDX_W-1:0]          slot;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid & cfg.ready;
	assign slot      = cfg.index - orm_pkg::REG_RULE_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rules_q <= '0;
		end else if (wr) begin
			if (cfg.index == orm_pkg::REG_RULE_COUNT) begin
				count_q <= cfg.data[orm_pkg::COUNT_W-1:0];
			end else if (cfg.index <= orm_pkg::REG_RULE_LAST) begin
				rules_q[slot] <= orm_pkg::rule_t'(cfg.data);
			end
		end
	end

	// Saturate the count to the rules that exist
	assign limit = (count_q > orm_pkg::COUNT_W'(orm_pkg::MAX_RULES)) ?
		orm_pkg::COUNT_W'(orm_pkg::MAX_RULES) : count_q;

	always_comb begin
		ruleset.rules = rules_q;
		for (int i = 0; i < orm_pkg::MAX_RULES; i++) begin
			ruleset.active[i] = (orm_pkg::COUNT_W'(i) < limit);
		end
	end

endmodule

### rtl/core/orm_cell.sv
// ----------------------------------------------------------------------------
// orm_cell: one rule cell of the chain
// Applies one rule to the passing header and registers it for the next cell.
// ----------------------------------------------------------------------------
module orm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  orm_pkg::pay_t  in_pay,
	input  orm_pkg::rule_t rule,
	input  logic           active,
	output logic           out_valid,
	output orm_pkg::pay_t  out_pay
);

	logic          valid_q;
	orm_pkg::pay_t pay_q;
	orm_pkg::pay_t nxt;
	logic          hit;

	assign hit = active & ~in_pay.done
		& (rule.src_wild | (rule.orig_proto == in_pay.hdr.orig_proto))
		& (rule.dst_wild | (rule.dest_proto == in_pay.hdr.dest_proto));

	always_comb begin
		nxt = in_pay;
		if (hit && rule.modify) begin
			case (rule.ts_code)
				orm_pkg::TS_SLOT_ONE: nxt.hdr.timeslot = 1'b0;
				orm_pkg::TS_SLOT_TWO: nxt.hdr.timeslot = 1'b1;
				default:              nxt.hdr.timeslot = in_pay.hdr.timeslot;
			endcase
			case (rule.ct_code)
				orm_pkg::CT_GROUP:   nxt.hdr.call_type = orm_pkg::CALL_GROUP;
				orm_pkg::CT_PRIVATE: nxt.hdr.call_type = orm_pkg::CALL_PRIVATE;
				default:             nxt.hdr.call_type = in_pay.hdr.call_type;
			endcase
			if (rule.rw_source_id != '0) begin
				nxt.hdr.source_id = rule.rw_source_id;
			end
			if (rule.rw_target_id != '0) begin
				nxt.hdr.target_id = rule.rw_target_id;
			end
		end
		// Reject stops all later cells from touching this header
		if (hit && rule.reject) begin
			nxt.permit = 1'b0;
			nxt.done   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_pay   = pay_q;

endmodule

### rtl/core/ordered_rule_match_rewrite_unit.sv
// ----------------------------------------------------------------------------
// ordered_rule_match_rewrite_unit: ordered rule match and header rewrite
// Runs each packet header through a chain of rule cells, one per rule.
// ----------------------------------------------------------------------------
// Usage:
//   hdr  - input channel, one packet header per beat.
//   res  - output channel, one result per header: permit bit plus the
//          header as it stands after every rewrite that took place.
//   cfg  - register writes: index 0 is the rule count, 1..MAX_RULES the
//          packed rules. Always ready. Write only while the chain is empty.
// From header beat to result beat, cell i evaluates rule i and registers the
// header for cell i+1; the last cell's register drives the result channel.
// Throughput is one header per cycle while the receiver takes results.
// A rejecting rule marks the header done, so later cells pass it untouched.
// Reset clears the rule count, the rules and all stage valid bits.
// When the receiver stalls with a result pending, the whole chain holds and
// hdr.ready drops; it resumes in the cycle the result beat is taken.
// ----------------------------------------------------------------------------
module ordered_rule_match_rewrite_unit (
	input  logic      clk,
	input  logic      arst_n,
	orm_hdr_if.sink   hdr,
	orm_res_if.source res,
	orm_cfg_if.sink   cfg
);

	orm_pkg::ruleset_t                     ruleset;
	logic          [orm_pkg::MAX_RULES:0]   stage_valid;
	orm_pkg::pay_t [orm_pkg::MAX_RULES:0]   stage_pay;
	logic                                   en;

	// Register file for the rule set
	orm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.ruleset (ruleset)
	);

	// Advance the chain unless a finished result is waiting
	assign en        = ~res.valid | res.ready;
	assign hdr.ready = en;

	// Entry of the chain: fresh header, permitted, not yet decided
	assign stage_valid[0]              = hdr.valid;
	assign stage_pay[0].hdr.orig_proto = hdr.orig_proto;
	assign stage_pay[0].hdr.dest_proto = hdr.dest_proto;
	assign stage_pay[0].hdr.timeslot   = hdr.timeslot;
	assign stage_pay[0].hdr.call_type  = hdr.call_type;
	assign stage_pay[0].hdr.source_id  = hdr.source_id;
	assign stage_pay[0].hdr.target_id  = hdr.target_id;
	assign stage_pay[0].permit         = 1'b1;
	assign stage_pay[0].done           = 1'b0;

	// One cell per rule, in rule order
	for (genvar i = 0; i < orm_pkg::MAX_RULES; i++) begin : g_cell
		orm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (stage_valid[i]),
			.in_pay    (stage_pay[i]),
			.rule      (ruleset.rules[i]),
			.active    (ruleset.active[i]),
			.out_valid (stage_valid[i+1]),
			.out_pay   (stage_pay[i+1])
		);
	end

	// Last cell's register is the output register
	assign res.valid         = stage_valid[orm_pkg::MAX_RULES];
	assign res.permit        = stage_pay[orm_pkg::MAX_RULES].permit;
	assign res.new_timeslot  = stage_pay[orm_pkg::MAX_RULES].hdr.timeslot;
	assign res.new_call_type = stage_pay[orm_pkg::MAX_RULES].hdr.call_type;
	assign res.new_source_id = stage_pay[orm_pkg::MAX_RULES].hdr.source_id;
	assign res.new_target_id = stage_pay[orm_pkg::MAX_RULES].hdr.target_id;

	logic [orm_pkg::MAX_RULES-1:0] reject_active;
	always_comb begin
		for (int i = 0; i < orm_pkg::MAX_RULES; i++) begin
			reject_active[i] = ruleset.rules[i].reject & ruleset.active[i];
		end
	end

	// A rejected result needs at least one active reject rule
	a_reject_needs_rule: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.permit |-> reject_active != '0)
		else $error("reject without an active reject rule");

	// With no active rule every header is permitted
	a_empty_permits: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && ruleset.active == '0 |-> res.permit)
		else $error("reject with an empty rule set");

	// Permit and the done mark agree at the chain end
	a_done_matches_permit: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (stage_pay[orm_pkg::MAX_RULES].done == !res.permit))
		else $error("done mark and permit disagree");

	// A header accepted with the chain moving reaches the first cell register
	a_entry_advances: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && hdr.ready |=> stage_valid[1])
		else $error("accepted header lost at chain entry");

endmodule
